/* design/u8u16_pkg.sv */
// Shared types and constants for the UTF-8 to UTF-16 decoder.
// Used by the front, queue, back and top-level modules; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package u8u16_pkg;

  // Command handed from the decoder front to the emitter back
  typedef enum logic [1:0] {
    CMD_SCALAR,
    CMD_ILL,
    CMD_END,
    CMD_END_TRUNC
  } cmd_kind_t;

  localparam int SCALAR_W = 21;

  typedef struct packed {
    cmd_kind_t             kind;
    logic [SCALAR_W-1:0]   scalar;
  } cmd_t;

  // Result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ILL  = 2'd1;
  localparam logic [1:0] ST_ROOM = 2'd2;

  // Byte classes
  localparam logic [7:0] ASCII_LIMIT = 8'h80;
  localparam logic [7:0] LEAD2_LO    = 8'hC2;
  localparam logic [7:0] LEAD2_HI    = 8'hDF;
  localparam logic [7:0] LEAD3_LO    = 8'hE0;
  localparam logic [7:0] LEAD3_HI    = 8'hEF;
  localparam logic [7:0] LEAD4_LO    = 8'hF0;
  localparam logic [7:0] LEAD4_HI    = 8'hF4;
  localparam logic [1:0] CONT_TAG    = 2'b10;

  // Scalar range limits
  localparam logic [SCALAR_W-1:0] MIN_3BYTE  = 21'h000800;
  localparam logic [SCALAR_W-1:0] MIN_4BYTE  = 21'h010000;
  localparam logic [SCALAR_W-1:0] MAX_SCALAR = 21'h10FFFF;
  localparam logic [SCALAR_W-1:0] SURR_LO    = 21'h00D800;
  localparam logic [SCALAR_W-1:0] SURR_HI    = 21'h00DFFF;

  // Surrogate pair bases
  localparam logic [15:0] HI_SURR_BASE = 16'hD800;
  localparam logic [15:0] LO_SURR_BASE = 16'hDC00;

endpackage

`default_nettype wire

/* design/utf8_to_utf16_validating_decoder_unit.sv */
// UTF-8 to UTF-16 validating decoder, top level.
// Instantiates u8u16_front, u8u16_queue and u8u16_back; uses u8u16_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall): one UTF-8 byte per request on
//   data_byte, or an end marker with string_end high. Output channel
//   (out_valid / out_stall): one UTF-16 unit per request (is_unit high),
//   or the closing request of a string (is_final high) carrying status
//   and unit_count. A scalar above the BMP gives two unit requests.
//   Configuration (cfg_valid / cfg_ready): cfg_data writes max_units; the
//   port is always ready. Write it only while no string is in flight.
// Timing:
//   One byte accepted per cycle while in_stall is low. A result for the byte
//   that completes it passes through the command queue and then the
//   output register. A surrogate pair gives two back-end results, which
//   the queue absorbs; sustained rate is set by the back end emitting one
//   result per cycle while out_stall is low.
// Reset and stall:
//   Synchronous reset clears decode state, empties the queue, clears out_valid
//   and sets max_units to 65535. While out_stall is high the
//   output holds; the queue fills and then in_stall rises.
`timescale 1ns / 1ps
`default_nettype none

module utf8_to_utf16_validating_decoder_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        string_end,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      code_unit,
  output logic             is_unit,
  output logic             is_final,
  output logic [1:0]       status,
  output logic [15:0]      unit_count,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);

  logic [15:0]     max_units;
  logic            queue_full;
  logic            push;
  u8u16_pkg::cmd_t push_cmd;
  logic            pop;
  logic            head_valid;
  u8u16_pkg::cmd_t head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_units <= 16'hFFFF;
    end else if (cfg_valid && cfg_ready) begin
      max_units <= cfg_data;
    end
  end

  u8u16_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .string_end (string_end),
    .queue_full (queue_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  u8u16_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .full       (queue_full),
    .head_valid (head_valid),
    .head       (head)
  );

  u8u16_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .max_units  (max_units),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .code_unit  (code_unit),
    .is_unit    (is_unit),
    .is_final   (is_final),
    .status     (status),
    .unit_count (unit_count)
  );

endmodule

`default_nettype wire

/* design/u8u16_front.sv */
// Decoder front: accepts bytes, gathers UTF-8 sequences and validates them.
// Pushes scalar, error and end commands into the queue. Depends on u8u16_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u8u16_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        data_byte,
  input  wire logic              string_end,
  input  wire logic              queue_full,
  output logic                   push,
  output u8u16_pkg::cmd_t        push_cmd
);

  logic [1:0]  pend, pend_next;
  logic [1:0]  seqlen, seqlen_next;
  logic [20:0] partial, partial_next;
  logic        ill, ill_next;
  logic        accept;
  logic [20:0] cont_acc;
  logic        cp_bad;

  assign in_stall = queue_full;
  assign accept   = in_valid && !queue_full;
  assign cont_acc = {partial[14:0], data_byte[5:0]};

  always_comb begin
    cp_bad = 1'b0;
    if (seqlen == 2'd2) begin
      cp_bad = (cont_acc < u8u16_pkg::MIN_3BYTE) ||
               ((cont_acc >= u8u16_pkg::SURR_LO) && (cont_acc <= u8u16_pkg::SURR_HI));
    end else if (seqlen == 2'd3) begin
      cp_bad = (cont_acc < u8u16_pkg::MIN_4BYTE) || (cont_acc > u8u16_pkg::MAX_SCALAR);
    end
  end

  always_comb begin
    pend_next    = pend;
    seqlen_next  = seqlen;
    partial_next = partial;
    ill_next     = ill;
    push         = 1'b0;
    push_cmd     = '{kind: u8u16_pkg::CMD_SCALAR, scalar: '0};
    if (accept) begin
      if (string_end) begin
        push          = 1'b1;
        push_cmd.kind = (pend != 2'd0 && !ill) ? u8u16_pkg::CMD_END_TRUNC
                                               : u8u16_pkg::CMD_END;
        pend_next     = 2'd0;
        seqlen_next   = 2'd0;
        partial_next  = '0;
        ill_next      = 1'b0;
      end else if (ill) begin
        // swallow bytes until the end marker
        push = 1'b0;
      end else if (pend == 2'd0) begin
        if (data_byte < u8u16_pkg::ASCII_LIMIT) begin
          push            = 1'b1;
          push_cmd.scalar = {13'd0, data_byte};
        end else if (data_byte >= u8u16_pkg::LEAD2_LO && data_byte <= u8u16_pkg::LEAD2_HI) begin
          seqlen_next  = 2'd1;
          pend_next    = 2'd1;
          partial_next = {16'd0, data_byte[4:0]};
        end else if (data_byte >= u8u16_pkg::LEAD3_LO && data_byte <= u8u16_pkg::LEAD3_HI) begin
          seqlen_next  = 2'd2;
          pend_next    = 2'd2;
          partial_next = {17'd0, data_byte[3:0]};
        end else if (data_byte >= u8u16_pkg::LEAD4_LO && data_byte <= u8u16_pkg::LEAD4_HI) begin
          seqlen_next  = 2'd3;
          pend_next    = 2'd3;
          partial_next = {18'd0, data_byte[2:0]};
        end else begin
          push          = 1'b1;
          push_cmd.kind = u8u16_pkg::CMD_ILL;
          ill_next      = 1'b1;
        end
      end else if (data_byte[7:6] != u8u16_pkg::CONT_TAG) begin
        push          = 1'b1;
        push_cmd.kind = u8u16_pkg::CMD_ILL;
        ill_next      = 1'b1;
        pend_next     = 2'd0;
      end else begin
        pend_next    = pend - 2'd1;
        partial_next = cont_acc;
        if (pend == 2'd1) begin
          partial_next = '0;
          push         = 1'b1;
          if (cp_bad) begin
            push_cmd.kind = u8u16_pkg::CMD_ILL;
            ill_next      = 1'b1;
          end else begin
            push_cmd.scalar = cont_acc;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend    <= 2'd0;
      seqlen  <= 2'd0;
      partial <= '0;
      ill     <= 1'b0;
    end else begin
      pend    <= pend_next;
      seqlen  <= seqlen_next;
      partial <= partial_next;
      ill     <= ill_next;
    end
  end

endmodule

`default_nettype wire

/* design/u8u16_queue.sv */
// Small command queue between the decoder front and the emitter back.
// Register-based circular buffer. Depends on u8u16_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u8u16_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire u8u16_pkg::cmd_t   push_cmd,
  input  wire logic              pop,
  output logic                   full,
  output logic                   head_valid,
  output u8u16_pkg::cmd_t        head
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  u8u16_pkg::cmd_t entries [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push, do_pop;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* design/u8u16_back.sv */
// Emitter back: checks output capacity, splits scalars into UTF-16 units
// and builds the closing result. Holds the output register. Depends on u8u16_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u8u16_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              head_valid,
  input  wire u8u16_pkg::cmd_t   head,
  output logic                   pop,
  input  wire logic [15:0]       max_units,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [15:0]            code_unit,
  output logic                   is_unit,
  output logic                   is_final,
  output logic [1:0]             status,
  output logic [15:0]            unit_count
);

  logic [15:0] units, units_next;
  logic [1:0]  fault, fault_next;
  logic        phase, phase_next;
  logic        slot_free;
  logic        load;
  logic [15:0] ld_unit;
  logic        ld_is_unit;
  logic [1:0]  ld_status;
  logic [15:0] ld_count;
  logic        is_pair;
  logic [19:0] pair_off;
  logic        no_room_bmp, no_room_pair;

  assign slot_free    = !out_valid || !out_stall;
  assign is_pair      = (head.scalar[20:16] != 5'd0);
  assign pair_off     = 20'(head.scalar - u8u16_pkg::MIN_4BYTE);
  assign no_room_bmp  = ({2'b00, units} + 18'd2) > {2'b00, max_units};
  assign no_room_pair = ({2'b00, units} + 18'd3) > {2'b00, max_units};

  always_comb begin
    units_next = units;
    fault_next = fault;
    phase_next = phase;
    pop        = 1'b0;
    load       = 1'b0;
    ld_unit    = '0;
    ld_is_unit = 1'b1;
    ld_status  = u8u16_pkg::ST_OK;
    ld_count   = '0;
    if (head_valid) begin
      case (head.kind)
        u8u16_pkg::CMD_SCALAR: begin
          if (fault != u8u16_pkg::ST_OK) begin
            pop = 1'b1;
          end else if (!is_pair) begin
            if (no_room_bmp) begin
              fault_next = u8u16_pkg::ST_ROOM;
              pop        = 1'b1;
            end else if (slot_free) begin
              load       = 1'b1;
              ld_unit    = head.scalar[15:0];
              units_next = units + 16'd1;
              pop        = 1'b1;
            end
          end else if (!phase) begin
            if (no_room_pair) begin
              fault_next = u8u16_pkg::ST_ROOM;
              pop        = 1'b1;
            end else if (slot_free) begin
              load       = 1'b1;
              ld_unit    = u8u16_pkg::HI_SURR_BASE + {6'd0, pair_off[19:10]};
              units_next = units + 16'd1;
              phase_next = 1'b1;
            end
          end else if (slot_free) begin
            // low half of the pair; room was checked with the high half
            load       = 1'b1;
            ld_unit    = u8u16_pkg::LO_SURR_BASE + {6'd0, pair_off[9:0]};
            units_next = units + 16'd1;
            phase_next = 1'b0;
            pop        = 1'b1;
          end
        end
        u8u16_pkg::CMD_ILL: begin
          if (fault == u8u16_pkg::ST_OK) begin
            fault_next = u8u16_pkg::ST_ILL;
          end
          pop = 1'b1;
        end
        u8u16_pkg::CMD_END, u8u16_pkg::CMD_END_TRUNC: begin
          if (slot_free) begin
            load       = 1'b1;
            ld_is_unit = 1'b0;
            ld_count   = units;
            if (fault != u8u16_pkg::ST_OK) begin
              ld_status = fault;
            end else if (head.kind == u8u16_pkg::CMD_END_TRUNC) begin
              ld_status = u8u16_pkg::ST_ILL;
            end else if (max_units == 16'd0) begin
              ld_status = u8u16_pkg::ST_ROOM;
            end else begin
              ld_status = u8u16_pkg::ST_OK;
            end
            units_next = '0;
            fault_next = u8u16_pkg::ST_OK;
            phase_next = 1'b0;
            pop        = 1'b1;
          end
        end
        default: begin
          pop = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      units     <= '0;
      fault     <= u8u16_pkg::ST_OK;
      phase     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      units <= units_next;
      fault <= fault_next;
      phase <= phase_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      code_unit  <= ld_unit;
      is_unit    <= ld_is_unit;
      is_final   <= !ld_is_unit;
      status     <= ld_status;
      unit_count <= ld_count;
    end
  end

endmodule

`default_nettype wire

/* design/u8u16_checker.sv */
// Port-level checks for the UTF-8 to UTF-16 decoder top level.
// Bound to utf8_to_utf16_validating_decoder_unit; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module u8u16_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [15:0] code_unit,
  input wire logic        is_unit,
  input wire logic        is_final,
  input wire logic [1:0]  status,
  input wire logic [15:0] unit_count
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(code_unit) && $stable(status)
      && $stable(is_final) && $stable(unit_count))
    else $error("stalled result changed");

  // every result is exactly one of unit or closing
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_unit != is_final))
    else $error("result is neither unit nor closing");

  // unit results carry no status and no count
  assert property (@(posedge clk) disable iff (rst)
    out_valid && is_unit |-> status == 2'd0 && unit_count == 16'd0)
    else $error("unit result with status or count");

  // no undefined status code
  assert property (@(posedge clk) disable iff (rst)
    out_valid && is_final |-> status != 2'd3)
    else $error("undefined status code");

  // reset empties the output
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind utf8_to_utf16_validating_decoder_unit u8u16_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .code_unit  (code_unit),
  .is_unit    (is_unit),
  .is_final   (is_final),
  .status     (status),
  .unit_count (unit_count)
);

`default_nettype wire

/* dv/u8u16_result_checker.sv */
// Checker for the UTF-8 to UTF-16 decoder: watches the byte, result and
// capacity channels, predicts every result and compares it field by field.
// Depends on u8u16_pkg for status codes and encoding limits.
`timescale 1ns / 1ps

module u8u16_result_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        string_end,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] code_unit,
  input  logic        is_unit,
  input  logic        is_final,
  input  logic [1:0]  status,
  input  logic [15:0] unit_count,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          results_open,
  output int          strings_checked,
  output int          units_checked,
  output int          faulted_strings
);

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [15:0] unit;
    logic        has_unit;
    logic        closing;
    logic [1:0]  st;
    logic [15:0] count;
  } utf16_result_t;

  // Decoder state as the block should hold it
  logic [15:0]   capacity;
  logic [1:0]    cont_left;
  logic [1:0]    cont_total;
  logic [20:0]   scalar_acc;
  logic [15:0]   units_out;
  logic [1:0]    string_fault;
  utf16_result_t awaited_results[$];

  task automatic clear_string();
    cont_left    = 2'd0;
    cont_total   = 2'd0;
    scalar_acc   = 21'd0;
    units_out    = 16'd0;
    string_fault = u8u16_pkg::ST_OK;
  endtask

  // One unit for a BMP scalar, a surrogate pair above it; one unit stays free
  task automatic queue_scalar(input logic [20:0] cp);
    logic [19:0] offset;
    if (cp < u8u16_pkg::MIN_4BYTE) begin
      if (int'(units_out) + 2 > int'(capacity)) begin
        string_fault = u8u16_pkg::ST_ROOM;
      end else begin
        awaited_results.push_back('{cp[15:0], 1'b1, 1'b0, u8u16_pkg::ST_OK, 16'd0});
        units_out = units_out + 16'd1;
      end
    end else begin
      if (int'(units_out) + 3 > int'(capacity)) begin
        string_fault = u8u16_pkg::ST_ROOM;
      end else begin
        offset = 20'(cp - u8u16_pkg::MIN_4BYTE);
        awaited_results.push_back('{u8u16_pkg::HI_SURR_BASE + {6'd0, offset[19:10]},
                                    1'b1, 1'b0, u8u16_pkg::ST_OK, 16'd0});
        awaited_results.push_back('{u8u16_pkg::LO_SURR_BASE + {6'd0, offset[9:0]},
                                    1'b1, 1'b0, u8u16_pkg::ST_OK, 16'd0});
        units_out = units_out + 16'd2;
      end
    end
  endtask

  task automatic decode_request(input logic [7:0] b, input logic last);
    logic [1:0]  closing_status;
    logic [20:0] cp;
    logic        bad;
    if (last) begin
      if (string_fault != u8u16_pkg::ST_OK) closing_status = string_fault;
      else if (cont_left != 2'd0) closing_status = u8u16_pkg::ST_ILL;
      else if (capacity == 16'd0) closing_status = u8u16_pkg::ST_ROOM;
      else closing_status = u8u16_pkg::ST_OK;
      awaited_results.push_back('{16'd0, 1'b0, 1'b1, closing_status, units_out});
      clear_string();
    end else if (string_fault != u8u16_pkg::ST_OK) begin
      // drop everything until the end marker
    end else if (cont_left == 2'd0) begin
      if (b < u8u16_pkg::ASCII_LIMIT) begin
        queue_scalar({13'd0, b});
      end else if (b >= u8u16_pkg::LEAD2_LO && b <= u8u16_pkg::LEAD2_HI) begin
        cont_total = 2'd1;
        scalar_acc = {16'd0, b[4:0]};
      end else if (b >= u8u16_pkg::LEAD3_LO && b <= u8u16_pkg::LEAD3_HI) begin
        cont_total = 2'd2;
        scalar_acc = {17'd0, b[3:0]};
      end else if (b >= u8u16_pkg::LEAD4_LO && b <= u8u16_pkg::LEAD4_HI) begin
        cont_total = 2'd3;
        scalar_acc = {18'd0, b[2:0]};
      end else begin
        string_fault = u8u16_pkg::ST_ILL;
      end
      if (string_fault == u8u16_pkg::ST_OK && b >= u8u16_pkg::ASCII_LIMIT)
        cont_left = cont_total;
    end else if (b[7:6] != u8u16_pkg::CONT_TAG) begin
      // the offending byte is not reread as a lead
      string_fault = u8u16_pkg::ST_ILL;
      cont_left    = 2'd0;
    end else begin
      scalar_acc = {scalar_acc[14:0], b[5:0]};
      cont_left  = cont_left - 2'd1;
      if (cont_left == 2'd0) begin
        cp = scalar_acc;
        scalar_acc = 21'd0;
        bad = (cont_total == 2'd2 &&
               (cp < u8u16_pkg::MIN_3BYTE ||
                (cp >= u8u16_pkg::SURR_LO && cp <= u8u16_pkg::SURR_HI)))
           || (cont_total == 2'd3 &&
               (cp < u8u16_pkg::MIN_4BYTE || cp > u8u16_pkg::MAX_SCALAR));
        if (bad) string_fault = u8u16_pkg::ST_ILL;
        else queue_scalar(cp);
      end
    end
  endtask

  task automatic check_result();
    utf16_result_t seen;
    utf16_result_t want;
    seen = '{code_unit, is_unit, is_final, status, unit_count};
    if (awaited_results.size() == 0) begin
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
        $display("%0t: unexpected result unit=%h is_unit=%b is_final=%b status=%0d count=%0d",
                 $time, seen.unit, seen.has_unit, seen.closing, seen.st, seen.count);
    end else begin
      want = awaited_results.pop_front();
      if (seen !== want) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
          $display("%0t: result differs: expected unit=%h is_unit=%b is_final=%b status=%0d count=%0d",
                   $time, want.unit, want.has_unit, want.closing, want.st, want.count);
          $display("%0t:   got unit=%h is_unit=%b is_final=%b status=%0d count=%0d",
                   $time, seen.unit, seen.has_unit, seen.closing, seen.st, seen.count);
        end
      end
      if (want.closing) begin
        strings_checked++;
        if (want.st != u8u16_pkg::ST_OK) faulted_strings++;
      end else begin
        units_checked++;
      end
    end
  endtask

  // Compare first: a result leaving this edge never stems from a byte taken at it
  always @(posedge clk) begin
    if (rst) begin
      capacity = 16'hFFFF;
      clear_string();
      awaited_results.delete();
    end else begin
      if (out_valid && !out_stall) check_result();
      if (cfg_valid && cfg_ready) capacity = cfg_data;
      if (in_valid && !in_stall) decode_request(data_byte, string_end);
    end
    results_open = awaited_results.size();
  end

endmodule

/* dv/tb.sv */
// Top of the UTF-8 to UTF-16 decoder testbench: clock, reset, byte and
// capacity stimulus, stall patterns and the verdict. Uses u8u16_pkg and
// u8u16_result_checker beside the block.
`timescale 1ns / 1ps

module tb;

  localparam int QUIET_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 6;
  localparam int ITEM_GOAL     = 1550;
  localparam int PHASES        = 9;
  localparam int BROKEN_PCT    = 12;
  localparam logic [8:0] END_MARK = 9'h100;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic [7:0]  data_byte = 8'd0;
  logic        string_end = 1'b0;
  logic        out_stall = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [15:0] cfg_data = 16'd0;
  logic        in_stall;
  logic        out_valid;
  logic [15:0] code_unit;
  logic        is_unit;
  logic        is_final;
  logic [1:0]  status;
  logic [15:0] unit_count;
  logic        cfg_ready;

  int fail_count;
  int results_open;
  int strings_checked;
  int units_checked;
  int faulted_strings;
  int sender_idle_pct   = 21;
  int receiver_idle_pct = 68;
  int items_sent        = 0;

  always #5 clk = ~clk;

  utf8_to_utf16_validating_decoder_unit i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .string_end (string_end),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .code_unit  (code_unit),
    .is_unit    (is_unit),
    .is_final   (is_final),
    .status     (status),
    .unit_count (unit_count),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  u8u16_result_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .data_byte       (data_byte),
    .string_end      (string_end),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .code_unit       (code_unit),
    .is_unit         (is_unit),
    .is_final        (is_final),
    .status          (status),
    .unit_count      (unit_count),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .results_open    (results_open),
    .strings_checked (strings_checked),
    .units_checked   (units_checked),
    .faulted_strings (faulted_strings)
  );

  always @(negedge clk) out_stall <= ($urandom_range(0, 99) < receiver_idle_pct);

  // Every task starts and ends just after a falling edge
  task automatic send_request(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    data_byte  = b;
    string_end = last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_scalar_bytes(input logic [20:0] cp, input int len, input int nbytes);
    logic [7:0] seq_bytes [4];
    int k;
    case (len)
      1: seq_bytes[0] = cp[7:0];
      2: begin
        seq_bytes[0] = {3'b110, cp[10:6]};
        seq_bytes[1] = {u8u16_pkg::CONT_TAG, cp[5:0]};
      end
      3: begin
        seq_bytes[0] = {4'b1110, cp[15:12]};
        seq_bytes[1] = {u8u16_pkg::CONT_TAG, cp[11:6]};
        seq_bytes[2] = {u8u16_pkg::CONT_TAG, cp[5:0]};
      end
      default: begin
        seq_bytes[0] = {5'b11110, cp[20:18]};
        seq_bytes[1] = {u8u16_pkg::CONT_TAG, cp[17:12]};
        seq_bytes[2] = {u8u16_pkg::CONT_TAG, cp[11:6]};
        seq_bytes[3] = {u8u16_pkg::CONT_TAG, cp[5:0]};
      end
    endcase
    for (k = 0; k < nbytes; k++) send_request(seq_bytes[k], 1'b0);
  endtask

  // Well-formed scalar for the given encoded length, biased toward range edges
  function automatic logic [20:0] pick_scalar(input int len);
    logic [20:0] lo;
    logic [20:0] hi;
    int r;
    case (len)
      1: begin lo = 21'h0;     hi = 21'h7F;     end
      2: begin lo = 21'h80;    hi = 21'h7FF;    end
      3: begin lo = u8u16_pkg::MIN_3BYTE; hi = 21'hFFFF; end
      default: begin lo = u8u16_pkg::MIN_4BYTE; hi = u8u16_pkg::MAX_SCALAR; end
    endcase
    r = $urandom_range(0, 7);
    if (r == 0) return lo;
    if (r == 1) return hi;
    if (len == 3 && r == 2)
      return $urandom_range(0, 1) ? u8u16_pkg::SURR_LO - 21'd1
                                  : u8u16_pkg::SURR_HI + 21'd1;
    if (len == 3)
      return $urandom_range(0, 1)
        ? 21'($urandom_range(u8u16_pkg::MIN_3BYTE, u8u16_pkg::SURR_LO - 21'd1))
        : 21'($urandom_range(u8u16_pkg::SURR_HI + 21'd1, 21'hFFFF));
    return 21'($urandom_range(lo, hi));
  endfunction

  // Inject a likely ill-formed piece; some truncations also end the string
  task automatic send_broken_scalar(output logic closed);
    int kind;
    int len;
    logic [20:0] cp;
    logic [7:0] b;
    closed = 1'b0;
    kind = $urandom_range(0, 5);
    len  = $urandom_range(2, 4);
    case (kind)
      0: send_request(8'($urandom), 1'b0);
      1: begin
        // overlong form
        cp = (len == 2) ? 21'($urandom_range(0, 'h7F))
           : (len == 3) ? 21'($urandom_range(0, 'h7FF)) : 21'($urandom_range(0, 'hFFFF));
        send_scalar_bytes(cp, len, len);
      end
      2: send_scalar_bytes(21'($urandom_range(u8u16_pkg::SURR_LO, u8u16_pkg::SURR_HI)), 3, 3);
      3: send_scalar_bytes(21'($urandom_range('h110000, 'h1FFFFF)), 4, 4);
      4: begin
        send_scalar_bytes(pick_scalar(len), len, $urandom_range(1, len - 1));
        b = 8'($urandom);
        while (b[7:6] == u8u16_pkg::CONT_TAG) b = 8'($urandom);
        send_request(b, 1'b0);
      end
      default: begin
        send_scalar_bytes(pick_scalar(len), len, $urandom_range(1, len - 1));
        send_request(8'($urandom), 1'b1);
        closed = 1'b1;
      end
    endcase
  endtask

  task automatic send_string();
    int n_scalars;
    int s;
    int len;
    logic closed;
    closed = 1'b0;
    n_scalars = $urandom_range(0, 6);
    for (s = 0; s < n_scalars && !closed; s++) begin
      if ($urandom_range(0, 99) < BROKEN_PCT) begin
        send_broken_scalar(closed);
      end else begin
        len = $urandom_range(1, 4);
        send_scalar_bytes(pick_scalar(len), len, len);
      end
    end
    if (!closed) send_request(8'($urandom), 1'b1);
  endtask

  task automatic pause_for_results();
    in_valid = 1'b0;
    while (results_open != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [15:0] value);
    pause_for_results();
    cfg_valid = 1'b1;
    cfg_data  = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("utf8_to_utf16_validating_decoder_unit: mismatch");
    $finish;
  end

  initial begin : stimulus
    logic [8:0] directed_seq [28];
    logic [15:0] phase_capacity [PHASES];
    int i;
    int phase;

    directed_seq = '{
      // zero byte, ASCII top, two/three/four byte edges, then end
      9'h000, 9'h07F, 9'h0C2, 9'h080, 9'h0DF, 9'h0BF, 9'h0EF, 9'h0BF, 9'h0BF,
      9'h0F4, 9'h08F, 9'h0BF, 9'h0BF, END_MARK,
      // surrogate
      9'h0ED, 9'h0A0, 9'h080, END_MARK,
      // above U+10FFFF
      9'h0F4, 9'h090, 9'h080, 9'h080, END_MARK,
      // bad continuation, trailing byte swallowed
      9'h0C2, 9'h041, END_MARK,
      // truncated at the end
      9'h0C2, END_MARK
    };
    phase_capacity = '{16'd1, 16'd4, 16'd65535, 16'd0, 16'd3,
                       16'($urandom_range(1, 12)), 16'd2, 16'd7, 16'd65535};
    repeat (12) @(negedge clk);
    rst = 1'b0;

    for (i = 0; i < 28; i++) send_request(directed_seq[i][7:0], directed_seq[i][8]);

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase / 3)
        0: begin sender_idle_pct = 21; receiver_idle_pct = 68; end
        1: begin sender_idle_pct = 68; receiver_idle_pct = 21; end
        default: begin sender_idle_pct = 0; receiver_idle_pct = 0; end
      endcase
      write_capacity(phase_capacity[phase]);
      while (items_sent < (phase + 1) * ITEM_GOAL / PHASES) begin
        send_string();
        // hold off now and then until the output side has caught up
        if ($urandom_range(0, 19) == 0) pause_for_results();
      end
    end

    pause_for_results();
    $display("Checked %0d strings (%0d closed with a fault) and %0d code units from %0d requests.",
             strings_checked, faulted_strings, units_checked, items_sent);
    $display("Capacity swept from 0 to 65535 under three stall patterns on both channels.");
    if (fail_count == 0)
      $display("utf8_to_utf16_validating_decoder_unit: match");
    else
      $display("utf8_to_utf16_validating_decoder_unit: mismatch");
    $finish;
  end

endmodule
